FILE: hw/rtl/threshold_bounding_box_defines.svh
// Assertion macros shared by the bounding box RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef THRESHOLD_BOUNDING_BOX_DEFINES_SVH
`define THRESHOLD_BOUNDING_BOX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tbb_pkg.sv
// Package for the thresholded bounding box block: widths, register codes, types.
// Used by the stream interfaces, the tracker and the top level.
package tbb_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int COORD_W       = $clog2(MAX_DIMENSION);
    localparam int DIM_W         = COORD_W + 1;
    localparam int PIX_W         = 8;
    localparam int MARGIN_W      = 12;
    localparam int CFG_DATA_W    = 13;

    localparam logic [PIX_W-1:0]    THRESHOLD_RESET = PIX_W'(128);
    localparam logic [MARGIN_W-1:0] MARGIN_RESET    = '0;
    localparam logic [DIM_W-1:0]    WIDTH_RESET     = DIM_W'(640);
    localparam logic [DIM_W-1:0]    HEIGHT_RESET    = DIM_W'(480);

    typedef enum logic [1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_MARGIN       = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0]    threshold;
        logic [MARGIN_W-1:0] margin;
        logic [DIM_W-1:0]    width;   // already clamped to 1..MAX_DIMENSION
        logic [DIM_W-1:0]    height;  // already clamped to 1..MAX_DIMENSION
    } cfg_t;

    typedef struct packed {
        logic [DIM_W-1:0] min_x;
        logic [DIM_W-1:0] min_y;
        logic [DIM_W-1:0] max_x;
        logic [DIM_W-1:0] max_y;
        logic             empty;
    } box_result_t;

    // Out-of-range frame dimensions act as the nearest legal value.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (DIM_W'(v) > DIM_W'(MAX_DIMENSION) || CFG_DATA_W > DIM_W && (v >> DIM_W) != '0)
            r = DIM_W'(MAX_DIMENSION);
        else
            r = DIM_W'(v);
        return r;
    endfunction

endpackage

FILE: hw/rtl/tbb_stream_if.sv
// Valid/ready stream interfaces for pixel items and box result items.
// Depends on tbb_pkg for the field widths.
interface tbb_pixel_if import tbb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

interface tbb_box_if import tbb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] box_min_x;
    logic [DIM_W-1:0] box_min_y;
    logic [DIM_W-1:0] box_max_x;
    logic [DIM_W-1:0] box_max_y;
    logic             box_empty;

    modport source (output valid, output box_min_x, output box_min_y,
                    output box_max_x, output box_max_y, output box_empty, input ready);
    modport sink (input valid, input box_min_x, input box_min_y,
                  input box_max_x, input box_max_y, input box_empty, output ready);
endinterface

FILE: hw/rtl/threshold_bounding_box.sv
// Top level of the thresholded bounding box: configuration registers, input
// register, result register. Depends on tbb_pkg, tbb_stream_if and tbb_tracker.
//
//  channel  | direction | item
//  ---------+-----------+---------------------------------------------
//  pix      | in        | pixel_value, one grayscale pixel, raster order
//  box      | out       | box_min_x/y, box_max_x/y, box_empty per frame
//  cfg_*    | in        | write of threshold, margin, image_width/height
//
// One pixel is accepted every cycle unless the input stalls; a pixel is evaluated
// from the input register, against the box held in the tracker registers.
// The result of a frame appears in the cycle after its last pixel is evaluated.
// Input stalls only when a frame's last pixel meets a result still not taken.
// Reset restores the register defaults and clears the counters and the box.
`include "threshold_bounding_box_defines.svh"

module threshold_bounding_box import tbb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tbb_pixel_if.sink             pix,
    tbb_box_if.source             box,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              out_valid_reg;
    box_result_t       out_reg;

    logic              frame_end;
    logic              stall;
    logic              eval;
    box_result_t       result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= THRESHOLD_RESET;
            cfg_reg.margin    <= MARGIN_RESET;
            cfg_reg.width     <= WIDTH_RESET;
            cfg_reg.height    <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_THRESHOLD:    cfg_reg.threshold <= cfg_data[PIX_W-1:0];
                CFG_MARGIN:       cfg_reg.margin    <= cfg_data[MARGIN_W-1:0];
                CFG_IMAGE_WIDTH:  cfg_reg.width     <= clamp_dim(cfg_data);
                CFG_IMAGE_HEIGHT: cfg_reg.height    <= clamp_dim(cfg_data);
                default:          ;
            endcase
        end
    end

    // The last pixel of a frame waits in the input register while the
    // previous result is still held.
    assign stall     = in_valid_reg && frame_end && out_valid_reg && !box.ready;
    assign eval      = in_valid_reg && !stall;
    assign pix.ready = !in_valid_reg || !stall;

    tbb_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (eval),
        .pixel     (pix_reg),
        .frame_end (frame_end),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix.valid && pix.ready)
                in_valid_reg <= 1'b1;
            else if (eval)
                in_valid_reg <= 1'b0;

            if (eval && frame_end)
                out_valid_reg <= 1'b1;
            else if (box.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid && pix.ready)
            pix_reg <= pix.pixel_value;
        if (eval && frame_end)
            out_reg <= result;
    end

    assign box.valid     = out_valid_reg;
    assign box.box_min_x = out_reg.min_x;
    assign box.box_min_y = out_reg.min_y;
    assign box.box_max_x = out_reg.max_x;
    assign box.box_max_y = out_reg.max_y;
    assign box.box_empty = out_reg.empty;

    `TBB_ASSERT_NEXT(a_result_loaded, clk, rst_n, eval && frame_end, out_valid_reg,
        "frame end did not raise a result")
    `TBB_ASSERT_NEXT(a_stall_holds_pixel, clk, rst_n, stall,
        in_valid_reg && $stable(pix_reg), "stalled pixel was lost")
    `TBB_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_reg && !box.ready,
        !(eval && frame_end), "pending result overwritten")

endmodule

FILE: hw/rtl/tbb_tracker.sv
// Raster counters and running foreground box; forms the grown, clamped result.
// Depends on tbb_pkg and the assertion macros header.
`include "threshold_bounding_box_defines.svh"

module tbb_tracker import tbb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             step,
    input  logic [PIX_W-1:0] pixel,
    output logic             frame_end,
    output box_result_t      result
);

    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] low_x_reg, low_x_next;
    logic [COORD_W-1:0] low_y_reg, low_y_next;
    logic [COORD_W-1:0] high_x_reg, high_x_next;
    logic [COORD_W-1:0] high_y_reg, high_y_next;
    logic               found_reg, found_next;

    logic               hit;
    logic               row_end;
    logic [DIM_W-1:0]   col_inc;
    logic [DIM_W-1:0]   row_inc;
    logic [DIM_W-1:0]   grown_x;
    logic [DIM_W-1:0]   grown_y;
    logic [COORD_W-1:0] marg;

    assign hit     = pixel > cfg.threshold;
    assign col_inc = {1'b0, col_reg} + DIM_W'(1);
    assign row_inc = {1'b0, row_reg} + DIM_W'(1);
    // A counter left beyond the size by a mid-frame resize still ends its row or frame.
    assign row_end   = col_inc >= cfg.width;
    assign frame_end = row_end && (row_inc >= cfg.height);

    always_comb
    begin
        low_x_next  = low_x_reg;
        low_y_next  = low_y_reg;
        high_x_next = high_x_reg;
        high_y_next = high_y_reg;
        found_next  = found_reg;
        if (hit)
        begin
            found_next = 1'b1;
            if (!found_reg)
            begin
                low_x_next  = col_reg;
                high_x_next = col_reg;
                low_y_next  = row_reg;
                high_y_next = row_reg;
            end
            else
            begin
                if (col_reg < low_x_reg)  low_x_next  = col_reg;
                if (col_reg > high_x_reg) high_x_next = col_reg;
                if (row_reg < low_y_reg)  low_y_next  = row_reg;
                if (row_reg > high_y_reg) high_y_next = row_reg;
            end
        end

        col_next = row_end ? '0 : col_inc[COORD_W-1:0];
        row_next = row_reg;
        if (row_end)
            row_next = frame_end ? '0 : row_inc[COORD_W-1:0];
    end

    // Result from the box that includes the current pixel.
    assign marg    = COORD_W'(cfg.margin);
    assign grown_x = {1'b0, high_x_next} + DIM_W'(cfg.margin);
    assign grown_y = {1'b0, high_y_next} + DIM_W'(cfg.margin);

    always_comb
    begin
        result = '0;
        result.empty = !found_next;
        if (found_next)
        begin
            result.min_x = (low_x_next > marg) ? DIM_W'(low_x_next - marg) : '0;
            result.min_y = (low_y_next > marg) ? DIM_W'(low_y_next - marg) : '0;
            result.max_x = (grown_x > cfg.width)  ? cfg.width  : grown_x;
            result.max_y = (grown_y > cfg.height) ? cfg.height : grown_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            low_x_reg  <= '0;
            low_y_reg  <= '0;
            high_x_reg <= '0;
            high_y_reg <= '0;
            found_reg  <= 1'b0;
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (frame_end)
            begin
                low_x_reg  <= '0;
                low_y_reg  <= '0;
                high_x_reg <= '0;
                high_y_reg <= '0;
                found_reg  <= 1'b0;
            end
            else
            begin
                low_x_reg  <= low_x_next;
                low_y_reg  <= low_y_next;
                high_x_reg <= high_x_next;
                high_y_reg <= high_y_next;
                found_reg  <= found_next;
            end
        end
    end

    `TBB_ASSERT_NEXT(a_frame_restart, clk, rst_n, step && frame_end,
        col_reg == '0 && row_reg == '0 && !found_reg, "frame state not cleared after last pixel")
    `TBB_ASSERT_NOW(a_box_ordered, clk, rst_n, found_reg,
        low_x_reg <= high_x_reg && low_y_reg <= high_y_reg, "running box is inverted")
    `TBB_ASSERT_NOW(a_empty_result, clk, rst_n, result.empty,
        result.min_x == '0 && result.max_x == '0 && result.min_y == '0 && result.max_y == '0,
        "empty result carries coordinates")

endmodule

FILE: test/threshold_bounding_box_tb.sv
// Testbench for threshold_bounding_box: directed and random pixel streams are checked
// against a frame-level box predictor held in a small in-order scoreboard.
// Depends on tbb_pkg, the stream interfaces and the top level of the RTL.
module threshold_bounding_box_tb import tbb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 2000;
    localparam int IDLE_PCT      = 27;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;

    // Predicts the box of every frame and checks the boxes in arrival order.
    class box_scoreboard;
        logic [PIX_W-1:0]      threshold;
        logic [MARGIN_W-1:0]   margin;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        int unsigned           col, row, low_x, low_y, high_x, high_y;
        bit                    found;
        box_result_t           expected_boxes[$];
        int                    errors, boxes_checked, empty_boxes, pixels_seen;

        function new();
            threshold     = 8'd128;
            margin        = '0;
            width_reg     = 13'd640;
            height_reg    = 13'd480;
            errors        = 0;
            boxes_checked = 0;
            empty_boxes   = 0;
            pixels_seen   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            col    = 0;
            row    = 0;
            low_x  = 0;
            low_y  = 0;
            high_x = 0;
            high_y = 0;
            found  = 1'b0;
        endfunction

        // A dimension of zero acts as one, anything above the maximum as the maximum.
        function int unsigned eff_dim(logic [CFG_DATA_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_DIMENSION)
                return MAX_DIMENSION;
            return v;
        endfunction

        function void set_config(logic [PIX_W-1:0] thr, logic [MARGIN_W-1:0] mar,
                                 logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
            threshold  = thr;
            margin     = mar;
            width_reg  = w;
            height_reg = h;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] p);
            int unsigned w, h, x, y;
            box_result_t b;
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);
            x = col;
            y = row;
            pixels_seen++;
            if (p > threshold)
            begin
                if (!found)
                begin
                    low_x  = x;
                    high_x = x;
                    low_y  = y;
                    high_y = y;
                    found  = 1'b1;
                end
                else
                begin
                    if (x < low_x)  low_x  = x;
                    if (x > high_x) high_x = x;
                    if (y < low_y)  low_y  = y;
                    if (y > high_y) high_y = y;
                end
            end
            // Counters may lie beyond a dimension that shrank mid-frame.
            if (x + 1 < w)
            begin
                col = x + 1;
                return;
            end
            col = 0;
            if (y + 1 < h)
            begin
                row = y + 1;
                return;
            end
            b       = '0;
            b.empty = !found;
            if (found)
            begin
                b.min_x = (low_x > margin) ? DIM_W'(low_x - margin) : '0;
                b.min_y = (low_y > margin) ? DIM_W'(low_y - margin) : '0;
                b.max_x = DIM_W'((high_x + margin > w) ? w : high_x + margin);
                b.max_y = DIM_W'((high_y + margin > h) ? h : high_y + margin);
            end
            expected_boxes.push_back(b);
            clear_frame();
        endfunction

        function void compare_field(string name, logic [DIM_W-1:0] want,
                                    logic [DIM_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_box(box_result_t got);
            box_result_t want;
            if (expected_boxes.size() == 0)
            begin
                $display("%0t: box with no frame pending: expected none, %s %0d,%0d %0d,%0d %0b",
                         $time, "got min, max, empty", got.min_x, got.min_y,
                         got.max_x, got.max_y, got.empty);
                errors++;
                return;
            end
            want = expected_boxes.pop_front();
            boxes_checked++;
            if (want.empty)
                empty_boxes++;
            compare_field("box_min_x", want.min_x, got.min_x);
            compare_field("box_min_y", want.min_y, got.min_y);
            compare_field("box_max_x", want.max_x, got.max_x);
            compare_field("box_max_y", want.max_y, got.max_y);
            compare_field("box_empty", DIM_W'(want.empty), DIM_W'(got.empty));
        endfunction

        function int pending();
            return expected_boxes.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    hold_req;
    bit                    no_idle;
    int                    random_pixels;
    int                    settings_loaded;
    box_scoreboard         board = new();

    tbb_pixel_if pix_if ();
    tbb_box_if   box_if ();

    threshold_bounding_box u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_if),
        .box       (box_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic offer_pixel(input logic [PIX_W-1:0] value);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= value;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        board.note_pixel(value);
    endtask

    // Pixels that end no frame leave no expectation, so the task waits on past the
    // last expected box to let the pipeline settle before the registers change.
    task automatic wait_for_boxes();
        pix_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [PIX_W-1:0] thr, input logic [MARGIN_W-1:0] mar,
                                 input logic [CFG_DATA_W-1:0] w,
                                 input logic [CFG_DATA_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_index <= CFG_MARGIN;
        cfg_data  <= CFG_DATA_W'(mar);
        @(posedge clk);
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_config(thr, mar, w, h);
        settings_loaded++;
    endtask

    // fg is the percentage of pixels placed above the threshold, apart from one pick in ten that takes any value.
    function automatic logic [PIX_W-1:0] pick_pixel(input int thr, input int fg);
        if ($urandom_range(9) == 0)
            return PIX_W'($urandom_range(255));
        if (thr < 255 && $urandom_range(99) < fg)
            return PIX_W'($urandom_range(thr + 1, 255));
        return PIX_W'($urandom_range(thr));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(15))
            0: return '0;
            1: return CFG_DATA_W'($urandom_range(9, 24));
            default: return CFG_DATA_W'($urandom_range(1, 8));
        endcase
    endfunction

    // A phase may stop in the middle of a frame, so the next settings take
    // effect on a partly gathered box.
    task automatic random_phase(input int fixed_pix, input bit tiny);
        logic [PIX_W-1:0]      thr;
        logic [MARGIN_W-1:0]   mar;
        logic [CFG_DATA_W-1:0] w, h;
        int                    fg, area, npix;
        case ($urandom_range(7))
            0: thr = '0;
            1: thr = '1;
            default: thr = PIX_W'($urandom_range(255));
        endcase
        case ($urandom_range(7))
            0, 1: mar = '0;
            2: mar = '1;
            3: mar = MARGIN_W'($urandom_range(4095));
            default: mar = MARGIN_W'($urandom_range(1, 4));
        endcase
        if (tiny)
        begin
            w = CFG_DATA_W'($urandom_range(1, 2));
            h = CFG_DATA_W'($urandom_range(1, 2));
        end
        else
        begin
            w = pick_dim();
            h = pick_dim();
        end
        case ($urandom_range(3))
            0: fg = 0;
            1: fg = 3;
            2: fg = 25;
            default: fg = 70;
        endcase
        area = board.eff_dim(w) * board.eff_dim(h);
        if (fixed_pix > 0)
            npix = fixed_pix;
        else
            npix = ((area > 64) ? 1 : $urandom_range(1, 5)) * area +
                   (($urandom_range(3) == 0) ? $urandom_range(0, area - 1) : 0);
        load_settings(thr, mar, w, h);
        repeat (npix) offer_pixel(pick_pixel(thr, fg));
        wait_for_boxes();
        random_pixels += npix;
    endtask

    initial
    begin : result_sink
        int          hold_left;
        bit          hold_done;
        box_result_t got;
        hold_left = 0;
        hold_done = 1'b0;
        box_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && box_if.valid && box_if.ready)
            begin
                got.min_x = box_if.box_min_x;
                got.min_y = box_if.box_min_y;
                got.max_x = box_if.box_max_x;
                got.max_y = box_if.box_max_y;
                got.empty = box_if.box_empty;
                board.check_box(got);
            end
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                box_if.ready <= 1'b0;
            end
            else
                box_if.ready <= no_idle || $urandom_range(99) >= IDLE_PCT;
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        rst_n              <= 1'b0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel_value <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_THRESHOLD;
        cfg_data           <= '0;
        hold_req        = 1'b0;
        no_idle         = 1'b0;
        random_pixels   = 0;
        settings_loaded = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing can exceed the top threshold, so the frame comes out empty.
        load_settings(8'd255, 12'd0, 13'd2, 13'd2);
        offer_pixel(8'd255);
        offer_pixel(8'd0);
        offer_pixel(8'd255);
        offer_pixel(8'd128);
        wait_for_boxes();

        // A single foreground pixel sets both corners of the box.
        load_settings(8'd0, 12'd0, 13'd3, 13'd2);
        for (int i = 0; i < 6; i++)
            offer_pixel((i == 1) ? 8'd1 : 8'd0);
        wait_for_boxes();

        // The largest margin clamps every edge of the box.
        load_settings(8'd128, 12'd4095, 13'd3, 13'd3);
        for (int i = 0; i < 9; i++)
            offer_pixel((i == 4) ? 8'd129 : 8'd128);
        wait_for_boxes();

        // Zero dimensions act as a one-pixel frame.
        load_settings(8'd127, 12'd4095, 13'd0, 13'd0);
        offer_pixel(8'd128);
        wait_for_boxes();

        // The width shrinks in the middle of a frame; the column counter is then
        // past the new width and the gathered box is kept.
        load_settings(8'd100, 12'd1, 13'd2, 13'd3);
        offer_pixel(8'd0);
        offer_pixel(8'd0);
        offer_pixel(8'd0);
        wait_for_boxes();
        load_settings(8'd100, 12'd1, 13'd1, 13'd3);
        offer_pixel(8'd200);
        offer_pixel(8'd0);
        wait_for_boxes();

        // Dimensions above the maximum start a frame that a later small size ends.
        load_settings(8'd100, 12'd4095, 13'd8191, 13'd8191);
        for (int i = 0; i < 20; i++)
            offer_pixel((i == 10) ? 8'd200 : 8'd0);
        wait_for_boxes();
        load_settings(8'd100, 12'd4095, 13'd4, 13'd1);
        offer_pixel(8'd0);
        wait_for_boxes();

        phase = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            no_idle = (phase == 5);
            if (phase == 2)
            begin
                // Tiny frames while the output is held off fill the block up.
                hold_req = 1'b1;
                random_phase(80, 1'b1);
            end
            else if (phase == 5)
                random_phase(400, 1'b0);
            else
                random_phase(0, 1'b0);
            phase++;
        end
        no_idle = 1'b0;
        repeat (8) @(posedge clk);

        $display("Fed %0d pixels under %0d register settings, small frames and resizes.",
                 board.pixels_seen, settings_loaded);
        $display("Compared %0d boxes (%0d empty), with a long output stall and mid-frame changes.",
                 board.boxes_checked, board.empty_boxes);
        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
